// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== hdl/csl_pkg.sv =====
// Shared types, constants and lookup functions for the C subset lexer.
// No dependencies; used by every module of the block.
package csl_pkg;

   // Field widths
   localparam int KIND_BITS       = 6;
   localparam int CHAR_BITS       = 8;
   localparam int OFFSET_BITS     = 24;
   localparam int POSITION_BITS   = 16;
   localparam int LENGTH_BITS     = 16;
   localparam int KEYWORD_MAX_LEN = 8;
   localparam int WORD_IDX_BITS   = $clog2(KEYWORD_MAX_LEN);
   localparam int KW_BITS         = CHAR_BITS * KEYWORD_MAX_LEN;

   // Output queue sizing
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Token kinds
   localparam logic [KIND_BITS-1:0] KIND_END          = 6'd0;
   localparam logic [KIND_BITS-1:0] KIND_IDENT        = 6'd1;
   localparam logic [KIND_BITS-1:0] KIND_INT          = 6'd2;
   localparam logic [KIND_BITS-1:0] KIND_FLOAT        = 6'd3;
   localparam logic [KIND_BITS-1:0] KIND_KEYWORD_BASE = 6'd4;
   localparam logic [KIND_BITS-1:0] KIND_OP_BASE      = 6'd24;
   localparam logic [KIND_BITS-1:0] KIND_OP_LAST      = 6'd35;
   localparam logic [KIND_BITS-1:0] KIND_CHAR         = 6'd36;

   // Character codes
   localparam logic [CHAR_BITS-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_BITS-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_BITS-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_BITS-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CHAR_BITS-1:0] CHAR_SLASH = 8'h2F;

   // Keyword table, each entry right-justified and zero-padded
   localparam int KW_COUNT = 20;
   localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
      "void", "char", "int", "float", "double", "long", "short", "enum",
      "struct", "if", "else", "while", "do", "for", "goto", "return",
      "switch", "case", "break", "continue"
   };
   localparam int KW_LEN [KW_COUNT] = '{
      4, 4, 3, 5, 6, 4, 5, 4, 6, 2, 4, 5, 2, 3, 4, 6, 6, 4, 5, 8
   };

   // Two-character operator table
   localparam int OP_COUNT = 12;
   localparam logic [CHAR_BITS-1:0] OP_FIRST [OP_COUNT] = '{
      "+", "-", "=", "!", "<", ">", "+", "-", "*", "/", "&", "|"
   };
   localparam logic [CHAR_BITS-1:0] OP_SECOND [OP_COUNT] = '{
      "+", "-", "=", "=", "=", "=", "=", "=", "=", "=", "&", "|"
   };

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_IDENT   = 3'd1,
      MODE_INT     = 3'd2,
      MODE_FLOAT   = 3'd3,
      MODE_HELD    = 3'd4,
      MODE_COMMENT = 3'd5
   } scan_mode_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]     kind;
      logic [CHAR_BITS-1:0]     char_code;
      logic [OFFSET_BITS-1:0]   start_offset;
      logic [LENGTH_BITS-1:0]   length;
      logic [POSITION_BITS-1:0] row;
      logic [POSITION_BITS-1:0] column;
      logic                     last;
   } token_type;

   // Up to two tokens caused by one input transfer, in delivery order
   typedef struct packed {
      logic      v0;
      token_type t0;
      logic      v1;
      token_type t1;
   } emit_type;

   function automatic logic is_letter(input logic [CHAR_BITS-1:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
   endfunction

   function automatic logic is_digit(input logic [CHAR_BITS-1:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic is_space(input logic [CHAR_BITS-1:0] b);
      return b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_CR || b == CHAR_LF;
   endfunction

   function automatic logic is_op_first(input logic [CHAR_BITS-1:0] b);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < OP_COUNT; k++) begin
         if (OP_FIRST[k] == b) hit = 1'b1;
      end
      return hit;
   endfunction

   function automatic logic op_pair_hit(input logic [CHAR_BITS-1:0] a,
                                        input logic [CHAR_BITS-1:0] b);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < OP_COUNT; k++) begin
         if (OP_FIRST[k] == a && OP_SECOND[k] == b) hit = 1'b1;
      end
      return hit;
   endfunction

   function automatic logic [KIND_BITS-1:0] op_pair_kind(input logic [CHAR_BITS-1:0] a,
                                                         input logic [CHAR_BITS-1:0] b);
      logic [KIND_BITS-1:0] kind;
      kind = KIND_CHAR;
      for (int k = OP_COUNT - 1; k >= 0; k--) begin
         if (OP_FIRST[k] == a && OP_SECOND[k] == b) kind = KIND_OP_BASE + KIND_BITS'(k);
      end
      return kind;
   endfunction

   // Match a buffered word of the given length against the keyword table
   function automatic logic [KIND_BITS-1:0] keyword_kind(
      input logic [KEYWORD_MAX_LEN-1:0][CHAR_BITS-1:0] word,
      input logic [LENGTH_BITS-1:0]                    len);
      logic [KW_BITS-1:0]   cand;
      logic [KIND_BITS-1:0] kind;
      cand = '0;
      kind = KIND_IDENT;
      if (len != '0 && len <= LENGTH_BITS'(KEYWORD_MAX_LEN)) begin
         for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
            if (LENGTH_BITS'(i) < len) cand = {cand[KW_BITS-CHAR_BITS-1:0], word[i]};
         end
         for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (len == LENGTH_BITS'(KW_LEN[k]) && cand == KW_TEXT[k])
               kind = KIND_KEYWORD_BASE + KIND_BITS'(k);
         end
      end
      return kind;
   endfunction

endpackage

// ===== hdl/csl_scanner.sv =====
// Scanner: lexer state registers and the single-pass next-state / token logic.
// Depends on csl_pkg.
module csl_scanner (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic [csl_pkg::CHAR_BITS-1:0]         source_byte,
   input  logic                                  end_marker,
   output csl_pkg::emit_type                     emit
);

   localparam logic [csl_pkg::OFFSET_BITS-1:0]   OFF_MAX = '1;
   localparam logic [csl_pkg::POSITION_BITS-1:0] POS_MAX = '1;
   localparam logic [csl_pkg::LENGTH_BITS-1:0]   LEN_MAX = '1;

   csl_pkg::scan_mode_type                        mode_ff, mode_in;
   logic [csl_pkg::CHAR_BITS-1:0]                 held_ff, held_in;
   logic [csl_pkg::KEYWORD_MAX_LEN-1:0][csl_pkg::CHAR_BITS-1:0] word_ff;
   logic [csl_pkg::LENGTH_BITS-1:0]               run_len_ff, run_len_in;
   logic [csl_pkg::POSITION_BITS-1:0]             run_col_ff, run_col_in;
   logic [csl_pkg::OFFSET_BITS-1:0]               run_off_ff, run_off_in;
   logic [csl_pkg::POSITION_BITS-1:0]             line_ff, line_in;
   logic [csl_pkg::POSITION_BITS-1:0]             col_ff, col_in;
   logic [csl_pkg::OFFSET_BITS-1:0]               off_ff, off_in;

   logic                                          word_we;
   logic [csl_pkg::WORD_IDX_BITS-1:0]             word_idx;
   logic                                          do_fresh;
   logic                                          extend;

   // Next state and tokens for the byte on the input
   always_comb begin
      mode_in    = mode_ff;
      held_in    = held_ff;
      run_len_in = run_len_ff;
      run_col_in = run_col_ff;
      run_off_in = run_off_ff;
      line_in    = line_ff;
      col_in     = col_ff;
      off_in     = off_ff;
      word_we    = 1'b0;
      word_idx   = run_len_ff[csl_pkg::WORD_IDX_BITS-1:0];
      do_fresh   = 1'b0;
      extend     = 1'b0;

      // first slot: the pending run or held operator
      emit.v0              = 1'b0;
      emit.t0.kind         = csl_pkg::KIND_IDENT;
      emit.t0.char_code    = '0;
      emit.t0.start_offset = run_off_ff;
      emit.t0.length       = run_len_ff;
      emit.t0.row          = line_ff;
      emit.t0.column       = run_col_ff;
      emit.t0.last         = 1'b0;

      // second slot: a single-character token or the end token
      emit.v1              = 1'b0;
      emit.t1.kind         = csl_pkg::KIND_CHAR;
      emit.t1.char_code    = source_byte;
      emit.t1.start_offset = off_ff;
      emit.t1.length       = csl_pkg::LENGTH_BITS'(1);
      emit.t1.row          = line_ff;
      emit.t1.column       = col_ff;
      emit.t1.last         = 1'b1;

      if (end_marker) begin
         // flush the pending token, emit the end token, return to reset state
         case (mode_ff)
            csl_pkg::MODE_IDENT: begin
               emit.v0      = 1'b1;
               emit.t0.kind = csl_pkg::keyword_kind(word_ff, run_len_ff);
            end
            csl_pkg::MODE_INT: begin
               emit.v0      = 1'b1;
               emit.t0.kind = csl_pkg::KIND_INT;
            end
            csl_pkg::MODE_FLOAT: begin
               emit.v0      = 1'b1;
               emit.t0.kind = csl_pkg::KIND_FLOAT;
            end
            csl_pkg::MODE_HELD: begin
               emit.v0           = 1'b1;
               emit.t0.kind      = csl_pkg::KIND_CHAR;
               emit.t0.char_code = held_ff;
               emit.t0.length    = csl_pkg::LENGTH_BITS'(1);
            end
            default: ;
         endcase
         emit.v1           = 1'b1;
         emit.t1.kind      = csl_pkg::KIND_END;
         emit.t1.char_code = '0;
         emit.t1.length    = '0;
         mode_in    = csl_pkg::MODE_IDLE;
         held_in    = '0;
         run_len_in = '0;
         run_col_in = '0;
         run_off_in = '0;
         line_in    = '0;
         col_in     = '0;
         off_in     = '0;
      end else begin
         case (mode_ff)
            csl_pkg::MODE_COMMENT: begin
               if (source_byte == csl_pkg::CHAR_LF) mode_in = csl_pkg::MODE_IDLE;
            end
            csl_pkg::MODE_IDENT: begin
               if (csl_pkg::is_letter(source_byte)) begin
                  extend = 1'b1;
               end else begin
                  emit.v0      = 1'b1;
                  emit.t0.kind = csl_pkg::keyword_kind(word_ff, run_len_ff);
                  do_fresh     = 1'b1;
               end
            end
            csl_pkg::MODE_INT: begin
               if (csl_pkg::is_digit(source_byte)) begin
                  extend = 1'b1;
               end else if (source_byte == csl_pkg::CHAR_DOT) begin
                  mode_in = csl_pkg::MODE_FLOAT;
                  extend  = 1'b1;
               end else begin
                  emit.v0      = 1'b1;
                  emit.t0.kind = csl_pkg::KIND_INT;
                  do_fresh     = 1'b1;
               end
            end
            csl_pkg::MODE_FLOAT: begin
               if (csl_pkg::is_digit(source_byte)) begin
                  extend = 1'b1;
               end else begin
                  emit.v0      = 1'b1;
                  emit.t0.kind = csl_pkg::KIND_FLOAT;
                  do_fresh     = 1'b1;
               end
            end
            csl_pkg::MODE_HELD: begin
               if (held_ff == csl_pkg::CHAR_SLASH && source_byte == csl_pkg::CHAR_SLASH) begin
                  mode_in = csl_pkg::MODE_COMMENT;
               end else if (csl_pkg::op_pair_hit(held_ff, source_byte)) begin
                  emit.v0        = 1'b1;
                  emit.t0.kind   = csl_pkg::op_pair_kind(held_ff, source_byte);
                  emit.t0.length = csl_pkg::LENGTH_BITS'(2);
                  mode_in        = csl_pkg::MODE_IDLE;
               end else begin
                  emit.v0           = 1'b1;
                  emit.t0.kind      = csl_pkg::KIND_CHAR;
                  emit.t0.char_code = held_ff;
                  emit.t0.length    = csl_pkg::LENGTH_BITS'(1);
                  do_fresh          = 1'b1;
               end
            end
            csl_pkg::MODE_IDLE: do_fresh = 1'b1;
            default:            do_fresh = 1'b1;
         endcase

         // scan the byte as the possible start of a new token
         if (do_fresh) begin
            mode_in = csl_pkg::MODE_IDLE;
            if (csl_pkg::is_space(source_byte)) begin
               mode_in = csl_pkg::MODE_IDLE;
            end else if (csl_pkg::is_digit(source_byte) || csl_pkg::is_letter(source_byte) ||
                         csl_pkg::is_op_first(source_byte)) begin
               run_len_in = csl_pkg::LENGTH_BITS'(1);
               run_off_in = off_ff;
               run_col_in = col_ff;
               if (csl_pkg::is_digit(source_byte)) begin
                  mode_in = csl_pkg::MODE_INT;
               end else if (csl_pkg::is_letter(source_byte)) begin
                  mode_in  = csl_pkg::MODE_IDENT;
                  word_we  = 1'b1;
                  word_idx = '0;
               end else begin
                  mode_in = csl_pkg::MODE_HELD;
                  held_in = source_byte;
               end
            end else begin
               emit.v1 = 1'b1;
            end
         end

         // grow the current run, buffering identifier text up to keyword length
         if (extend) begin
            if (mode_ff == csl_pkg::MODE_IDENT &&
                run_len_ff < csl_pkg::LENGTH_BITS'(csl_pkg::KEYWORD_MAX_LEN))
               word_we = 1'b1;
            if (run_len_ff != LEN_MAX) run_len_in = run_len_ff + 1'b1;
         end

         // advance position counters, saturating
         if (off_ff != OFF_MAX) off_in = off_ff + 1'b1;
         if (source_byte == csl_pkg::CHAR_LF) begin
            if (line_ff != POS_MAX) line_in = line_ff + 1'b1;
            col_in = '0;
         end else if (col_ff != POS_MAX) begin
            col_in = col_ff + 1'b1;
         end
      end

      emit.t0.last = ~emit.v1;
   end

   // Hold control state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= csl_pkg::MODE_IDLE;
         held_ff    <= '0;
         run_len_ff <= '0;
         run_col_ff <= '0;
         run_off_ff <= '0;
         line_ff    <= '0;
         col_ff     <= '0;
         off_ff     <= '0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         held_ff    <= held_in;
         run_len_ff <= run_len_in;
         run_col_ff <= run_col_in;
         run_off_ff <= run_off_in;
         line_ff    <= line_in;
         col_ff     <= col_in;
         off_ff     <= off_in;
      end
   end

   // Buffer identifier text; entries are read only after being written
   always_ff @(posedge clock) begin
      if (accept && word_we) word_ff[word_idx] <= source_byte;
   end

endmodule

// ===== hdl/csl_queue.sv =====
// Output queue: up to two tokens in per transfer, one out per cycle while popped.
// Depends on csl_pkg.
module csl_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  csl_pkg::emit_type   emit,
   input  logic                pop,
   output logic                room,
   output logic                head_valid,
   output csl_pkg::token_type  head
);

   csl_pkg::token_type                tok_ff [csl_pkg::QUEUE_DEPTH];
   logic [csl_pkg::QPTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [csl_pkg::QPTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [csl_pkg::QCNT_BITS-1:0]     count_ff, count_in;
   logic                              we0, we1;
   logic [csl_pkg::QPTR_BITS-1:0]     addr1;
   logic                              do_pop;

   // Pack valid tokens into consecutive entries
   always_comb begin
      we0       = push & emit.v0;
      we1       = push & emit.v1;
      addr1     = wr_ptr_ff + csl_pkg::QPTR_BITS'(we0);
      do_pop    = pop & head_valid;
      wr_ptr_in = wr_ptr_ff + csl_pkg::QPTR_BITS'(we0) + csl_pkg::QPTR_BITS'(we1);
      rd_ptr_in = rd_ptr_ff + csl_pkg::QPTR_BITS'(do_pop);
      count_in  = count_ff + csl_pkg::QCNT_BITS'(we0) + csl_pkg::QCNT_BITS'(we1)
                  - csl_pkg::QCNT_BITS'(do_pop);
   end

   assign head_valid = count_ff != '0;
   assign head       = tok_ff[rd_ptr_ff];
   // room for the worst case of two tokens from one transfer
   assign room       = count_ff <= csl_pkg::QCNT_BITS'(csl_pkg::QUEUE_DEPTH - 2);

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store token payloads
   always_ff @(posedge clock) begin
      if (we0) tok_ff[wr_ptr_ff] <= emit.t0;
      if (we1) tok_ff[addr1]     <= emit.t1;
   end

endmodule

// ===== hdl/c_subset_lexer_core.sv =====
// Streaming lexer for a C subset. Takes one source byte per clock while req_stall is
// low: each accepted byte is scanned in the cycle it is taken and its zero, one or
// two tokens are written to a four-entry output queue, so a token can be taken
// from the rsp_ side in the cycle after the byte that completes it. req_stall rises
// only while the queue has fewer than two free entries, so the input rate is set
// by how fast the rsp_ side drains tokens (one per cycle while rsp_stall is low).
// Assert req_end_marker to flush the pending token and get the end token; the next
// byte starts a new source at offset, row and column zero. Depends on csl_pkg.
module c_subset_lexer_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [csl_pkg::CHAR_BITS-1:0]        req_source_byte,
   input  logic                                 req_end_marker,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [csl_pkg::KIND_BITS-1:0]        rsp_token_kind,
   output logic [csl_pkg::CHAR_BITS-1:0]        rsp_char_code,
   output logic [csl_pkg::OFFSET_BITS-1:0]      rsp_start_offset,
   output logic [csl_pkg::LENGTH_BITS-1:0]      rsp_token_length,
   output logic [csl_pkg::POSITION_BITS-1:0]    rsp_token_row,
   output logic [csl_pkg::POSITION_BITS-1:0]    rsp_token_column,
   output logic                                 rsp_last_of_run
);

   csl_pkg::emit_type   emit;
   csl_pkg::token_type  head;
   logic                room;
   logic                accept;

   // Accept a transfer whenever the queue can take two tokens
   assign req_stall = ~room;
   assign accept    = req_valid & room;

   csl_scanner u_scanner (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .source_byte (req_source_byte),
      .end_marker  (req_end_marker),
      .emit        (emit)
   );

   csl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .emit       (emit),
      .pop        (~rsp_stall),
      .room       (room),
      .head_valid (rsp_valid),
      .head       (head)
   );

   // Drive result fields from the queue head
   assign rsp_token_kind   = head.kind;
   assign rsp_char_code    = head.char_code;
   assign rsp_start_offset = head.start_offset;
   assign rsp_token_length = head.length;
   assign rsp_token_row    = head.row;
   assign rsp_token_column = head.column;
   assign rsp_last_of_run  = head.last;

endmodule

// ===== hdl/csl_checker.sv =====
// Port-level checker for c_subset_lexer_core, attached by bind.
// Depends on csl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module csl_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [csl_pkg::KIND_BITS-1:0]        rsp_token_kind,
   input logic [csl_pkg::CHAR_BITS-1:0]        rsp_char_code,
   input logic [csl_pkg::LENGTH_BITS-1:0]      rsp_token_length,
   input logic                                 rsp_last_of_run
);

   // A stalled result stays offered
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // The end token is empty and closes the run of its transfer
   `ASSERT_IMPLY(a_end_token, clock, reset,
      rsp_valid && rsp_token_kind == csl_pkg::KIND_END,
      rsp_token_length == '0 && rsp_char_code == '0 && rsp_last_of_run)

   // Only single-character tokens carry a code, and they are one byte long
   `ASSERT_IMPLY(a_char_code, clock, reset,
      rsp_valid && rsp_char_code != '0,
      rsp_token_kind == csl_pkg::KIND_CHAR && rsp_token_length == 16'd1)

   // Two-character operators are two bytes long
   `ASSERT_IMPLY(a_op_length, clock, reset,
      rsp_valid && rsp_token_kind >= csl_pkg::KIND_OP_BASE &&
      rsp_token_kind <= csl_pkg::KIND_OP_LAST,
      rsp_token_length == 16'd2)

endmodule

bind c_subset_lexer_core csl_checker u_checker (.*);

// ===== tb/tb_c_subset_lexer_core.sv =====
// Self-checking testbench for c_subset_lexer_core: directed rows, random C-like
// source in four idle/stall phases, then a held-operator flush; a token predictor
// checks each transfer. Depends on csl_pkg and c_subset_lexer_core.
`timescale 1ns / 1ps

module tb_c_subset_lexer_core;
   import csl_pkg::*;

   localparam int          TIMEOUT_NS     = 20_000_000;
   localparam int          PHASE_ITEMS    = 415;
   localparam int          HOLD_CYCLES    = 64;
   localparam int          DRAIN_CYCLES   = 16;
   localparam int          MAX_REPORTS    = 10;
   localparam int unsigned OFFSET_MAX     = (1 << OFFSET_BITS) - 1;
   localparam int unsigned POS_MAX        = (1 << POSITION_BITS) - 1;
   localparam int unsigned LEN_MAX        = (1 << LENGTH_BITS) - 1;

   typedef struct {
      logic [CHAR_BITS-1:0] b;
      bit                   fin;
      bit                   typed;
      token_type            tok;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [CHAR_BITS-1:0]     req_source_byte = '0;
   logic                     req_end_marker = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [KIND_BITS-1:0]     rsp_token_kind;
   logic [CHAR_BITS-1:0]     rsp_char_code;
   logic [OFFSET_BITS-1:0]   rsp_start_offset;
   logic [LENGTH_BITS-1:0]   rsp_token_length;
   logic [POSITION_BITS-1:0] rsp_token_row;
   logic [POSITION_BITS-1:0] rsp_token_column;
   logic                     rsp_last_of_run;

   c_subset_lexer_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_source_byte  (req_source_byte),
      .req_end_marker   (req_end_marker),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_char_code    (rsp_char_code),
      .rsp_start_offset (rsp_start_offset),
      .rsp_token_length (rsp_token_length),
      .rsp_token_row    (rsp_token_row),
      .rsp_token_column (rsp_token_column),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state
   scan_mode_type        lex_mode;
   logic [CHAR_BITS-1:0] held_char;
   logic [CHAR_BITS-1:0] word_buf [KEYWORD_MAX_LEN];
   int unsigned          run_len, run_col, run_off;
   int unsigned          cur_row, cur_col, cur_off;
   token_type            new_tokens [$];
   token_type            expected_tokens [$];

   string kw_words [20] = '{
      "void", "char", "int", "float", "double", "long", "short", "enum",
      "struct", "if", "else", "while", "do", "for", "goto", "return",
      "switch", "case", "break", "continue"
   };
   string op_pairs [12] = '{
      "++", "--", "==", "!=", "<=", ">=", "+=", "-=", "*=", "/=", "&&", "||"
   };
   string punct_chars = "(){}[];,.#?:~%^@$";

   // Stimulus control
   int           idle_pct = 0;
   int           stall_pct = 0;
   bit           hold_request = 1'b0;
   int           hold_left = 0;
   int           error_count = 0;
   int           phase_count;
   stim_row_type phase_items [$];
   stim_row_type offered = '{8'h00, 1'b0, 1'b0, '0};

   localparam int DIRECTED_COUNT = 24;
   stim_row_type directed_rows [DIRECTED_COUNT] = '{
      '{8'h00, 1'b1, 1'b1, '{KIND_END, 8'h00, 24'd0, 16'd0, 16'd0, 16'd0, 1'b1}},
      '{8'h00, 1'b0, 1'b1, '{KIND_CHAR, 8'h00, 24'd0, 16'd1, 16'd0, 16'd0, 1'b1}},
      '{8'hFF, 1'b0, 1'b1, '{KIND_CHAR, 8'hFF, 24'd1, 16'd1, 16'd0, 16'd1, 1'b1}},
      '{CHAR_SLASH, 1'b0, 1'b0, '0},
      '{CHAR_SLASH, 1'b0, 1'b0, '0},
      '{"q", 1'b0, 1'b0, '0},
      '{CHAR_LF, 1'b0, 1'b0, '0},
      '{"d", 1'b0, 1'b0, '0},
      '{"o", 1'b0, 1'b0, '0},
      '{"7", 1'b0, 1'b0, '0},
      '{CHAR_DOT, 1'b0, 1'b0, '0},
      '{"=", 1'b0, 1'b0, '0},
      '{"=", 1'b0, 1'b0, '0},
      '{"<", 1'b0, 1'b0, '0},
      '{"x", 1'b0, 1'b0, '0},
      '{CHAR_TAB, 1'b0, 1'b0, '0},
      '{"&", 1'b0, 1'b0, '0},
      '{8'hFF, 1'b1, 1'b0, '0},
      '{"b", 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b0, '0},
      '{CHAR_SLASH, 1'b0, 1'b0, '0},
      '{CHAR_SLASH, 1'b0, 1'b0, '0},
      '{"z", 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b0, '0}
   };

   // ---------------------------------------------------------------- predictor

   function automatic bit letter_char(logic [CHAR_BITS-1:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
   endfunction

   function automatic bit digit_char(logic [CHAR_BITS-1:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic bit blank_char(logic [CHAR_BITS-1:0] b);
      return b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_CR || b == CHAR_LF;
   endfunction

   function automatic bit op_starter(logic [CHAR_BITS-1:0] b);
      foreach (op_pairs[k]) if (op_pairs[k][0] == b) return 1'b1;
      return 1'b0;
   endfunction

   function automatic void clear_lexer();
      lex_mode  = MODE_IDLE;
      held_char = '0;
      foreach (word_buf[i]) word_buf[i] = '0;
      run_len = 0;
      run_col = 0;
      run_off = 0;
      cur_row = 0;
      cur_col = 0;
      cur_off = 0;
   endfunction

   function automatic void emit_token(logic [KIND_BITS-1:0] kind, logic [CHAR_BITS-1:0] code,
                                      int unsigned off, int unsigned len,
                                      int unsigned row, int unsigned col);
      token_type t;
      t.kind         = kind;
      t.char_code    = code;
      t.start_offset = OFFSET_BITS'(off);
      t.length       = LENGTH_BITS'(len);
      t.row          = POSITION_BITS'(row);
      t.column       = POSITION_BITS'(col);
      t.last         = 1'b0;
      new_tokens.push_back(t);
   endfunction

   function automatic void emit_run(logic [KIND_BITS-1:0] kind);
      emit_token(kind, '0, run_off, run_len, cur_row, run_col);
   endfunction

   // Identifier or keyword, from the buffered leading characters
   function automatic logic [KIND_BITS-1:0] word_kind();
      bit same;
      if (run_len == 0 || run_len > KEYWORD_MAX_LEN) return KIND_IDENT;
      foreach (kw_words[k]) begin
         if (kw_words[k].len() == run_len) begin
            same = 1'b1;
            for (int i = 0; i < run_len; i++) begin
               if (kw_words[k][i] != word_buf[i]) same = 1'b0;
            end
            if (same) return KIND_KEYWORD_BASE + KIND_BITS'(k);
         end
      end
      return KIND_IDENT;
   endfunction

   function automatic void start_run(scan_mode_type m);
      lex_mode = m;
      run_len  = 1;
      run_off  = cur_off;
      run_col  = cur_col;
   endfunction

   function automatic void extend_run(logic [CHAR_BITS-1:0] b);
      if (lex_mode == MODE_IDENT && run_len < KEYWORD_MAX_LEN) word_buf[run_len] = b;
      if (run_len < LEN_MAX) run_len++;
   endfunction

   // Scan a byte as the possible start of a new token
   function automatic void scan_new(logic [CHAR_BITS-1:0] b);
      lex_mode = MODE_IDLE;
      if (blank_char(b)) return;
      if (digit_char(b)) begin
         start_run(MODE_INT);
      end else if (letter_char(b)) begin
         start_run(MODE_IDENT);
         word_buf[0] = b;
      end else if (op_starter(b)) begin
         start_run(MODE_HELD);
         held_char = b;
      end else begin
         emit_token(KIND_CHAR, b, cur_off, 1, cur_row, cur_col);
      end
   endfunction

   function automatic void step_position(logic [CHAR_BITS-1:0] b);
      if (cur_off < OFFSET_MAX) cur_off++;
      if (b == CHAR_LF) begin
         if (cur_row < POS_MAX) cur_row++;
         cur_col = 0;
      end else if (cur_col < POS_MAX) begin
         cur_col++;
      end
   endfunction

   // Tokens caused by one accepted input transfer, left in new_tokens
   function automatic void lex_item(logic [CHAR_BITS-1:0] b, bit fin);
      int pair;
      new_tokens.delete();
      if (fin) begin
         case (lex_mode)
            MODE_IDENT: emit_run(word_kind());
            MODE_INT:   emit_run(KIND_INT);
            MODE_FLOAT: emit_run(KIND_FLOAT);
            MODE_HELD:  emit_token(KIND_CHAR, held_char, run_off, 1, cur_row, run_col);
            default: ;
         endcase
         emit_token(KIND_END, '0, cur_off, 0, cur_row, cur_col);
         clear_lexer();
      end else begin
         case (lex_mode)
            MODE_COMMENT: begin
               if (b == CHAR_LF) lex_mode = MODE_IDLE;
            end
            MODE_IDENT: begin
               if (letter_char(b)) begin
                  extend_run(b);
               end else begin
                  emit_run(word_kind());
                  scan_new(b);
               end
            end
            MODE_INT: begin
               if (digit_char(b)) begin
                  extend_run(b);
               end else if (b == CHAR_DOT) begin
                  lex_mode = MODE_FLOAT;
                  extend_run(b);
               end else begin
                  emit_run(KIND_INT);
                  scan_new(b);
               end
            end
            MODE_FLOAT: begin
               if (digit_char(b)) begin
                  extend_run(b);
               end else begin
                  emit_run(KIND_FLOAT);
                  scan_new(b);
               end
            end
            MODE_HELD: begin
               pair = -1;
               foreach (op_pairs[k]) begin
                  if (pair < 0 && op_pairs[k][0] == held_char && op_pairs[k][1] == b) pair = k;
               end
               if (held_char == CHAR_SLASH && b == CHAR_SLASH) begin
                  lex_mode = MODE_COMMENT;
               end else if (pair >= 0) begin
                  emit_token(KIND_OP_BASE + KIND_BITS'(pair), '0, run_off, 2, cur_row,
                             run_col);
                  lex_mode = MODE_IDLE;
               end else begin
                  emit_token(KIND_CHAR, held_char, run_off, 1, cur_row, run_col);
                  scan_new(b);
               end
            end
            default: scan_new(b);
         endcase
         step_position(b);
      end
      if (new_tokens.size() > 0) new_tokens[$].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic string token_text(token_type t);
      return $sformatf("kind=%0d char=%0d off=%0d len=%0d row=%0d col=%0d last=%0d",
                       t.kind, t.char_code, t.start_offset, t.length, t.row, t.column,
                       t.last);
   endfunction

   function automatic void note_error(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
   endfunction

   // Predict on each input transfer, compare on each token transfer
   always @(posedge clock) begin : track_tokens
      token_type got;
      token_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            lex_item(req_source_byte, req_end_marker);
            if (offered.typed) begin
               new_tokens.delete();
               new_tokens.push_back(offered.tok);
            end
            foreach (new_tokens[i]) expected_tokens.push_back(new_tokens[i]);
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_token_kind, rsp_char_code, rsp_start_offset, rsp_token_length,
                    rsp_token_row, rsp_token_column, rsp_last_of_run};
            if (expected_tokens.size() == 0) begin
               note_error({"unexpected token ", token_text(got)});
            end else begin
               want = expected_tokens.pop_front();
               if (got !== want)
                  note_error({"expected ", token_text(want), " got ", token_text(got)});
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   // Stall at random; hold off for a long stretch when asked
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic stim_row_type plain_row(logic [CHAR_BITS-1:0] b, bit fin);
      stim_row_type r;
      r.b     = b;
      r.fin   = fin;
      r.typed = 1'b0;
      r.tok   = '0;
      return r;
   endfunction

   function automatic void add_item(logic [CHAR_BITS-1:0] b, bit fin);
      phase_items.push_back(plain_row(b, fin));
      phase_count++;
   endfunction

   function automatic logic [CHAR_BITS-1:0] rand_letter();
      int r;
      r = $urandom_range(52);
      if (r < 26) return CHAR_BITS'("a" + r);
      if (r < 52) return CHAR_BITS'("A" + r - 26);
      return "_";
   endfunction

   // Append one C-like token, maybe an end marker, maybe a separator
   function automatic void add_snippet();
      int    pick;
      int    n;
      string w;
      pick = $urandom_range(99);
      if (pick < 15) begin
         w = kw_words[$urandom_range(19)];
         for (int i = 0; i < w.len(); i++) add_item(w[i], 1'b0);
         if ($urandom_range(4) == 0) add_item(rand_letter(), 1'b0);
      end else if (pick < 30) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
         repeat (n) add_item(rand_letter(), 1'b0);
      end else if (pick < 42) begin
         repeat ($urandom_range(1, 5)) add_item(CHAR_BITS'("0" + $urandom_range(9)), 1'b0);
      end else if (pick < 52) begin
         repeat ($urandom_range(1, 4)) add_item(CHAR_BITS'("0" + $urandom_range(9)), 1'b0);
         add_item(CHAR_DOT, 1'b0);
         repeat ($urandom_range(0, 3)) add_item(CHAR_BITS'("0" + $urandom_range(9)), 1'b0);
      end else if (pick < 66) begin
         w = op_pairs[$urandom_range(11)];
         add_item(w[0], 1'b0);
         add_item(w[1], 1'b0);
      end else if (pick < 74) begin
         add_item(op_pairs[$urandom_range(11)][0], 1'b0);
      end else if (pick < 80) begin
         add_item(CHAR_SLASH, 1'b0);
         add_item(CHAR_SLASH, 1'b0);
         repeat ($urandom_range(0, 8)) add_item(CHAR_BITS'($urandom_range(255)), 1'b0);
         if ($urandom_range(3) != 0) add_item(CHAR_LF, 1'b0);
      end else if (pick < 88) begin
         add_item(punct_chars[$urandom_range(punct_chars.len() - 1)], 1'b0);
      end else begin
         add_item(CHAR_BITS'($urandom_range(255)), 1'b0);
      end
      // flush mid-token now and then
      if ($urandom_range(99) < 3) add_item(CHAR_BITS'($urandom_range(255)), 1'b1);
      case ($urandom_range(7))
         0: add_item(CHAR_SPACE, 1'b0);
         1: add_item(CHAR_TAB, 1'b0);
         2: add_item(CHAR_CR, 1'b0);
         3: add_item(CHAR_LF, 1'b0);
         4: add_item(CHAR_SPACE, 1'b0);
         default: ;
      endcase
   endfunction

   // Offer one item at the falling edge and hold it until the transfer
   task automatic offer(input stim_row_type row);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      offered = row;
      req_valid       <= 1'b1;
      req_source_byte <= row.b;
      req_end_marker  <= row.fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      #(TIMEOUT_NS);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : run_test
      int phase_idle [4];
      int phase_stall [4];
      phase_idle  = '{0, 68, 0, 19};
      phase_stall = '{0, 0, 68, 19};
      clear_lexer();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows
      foreach (directed_rows[i]) offer(directed_rows[i]);

      // random source in idle/stall phases; long receiver hold-off in the first
      for (int p = 0; p < 4; p++) begin
         idle_pct  = phase_idle[p];
         stall_pct = phase_stall[p];
         if (p == 0) hold_request = 1'b1;
         phase_items.delete();
         phase_count = 0;
         while (phase_count < PHASE_ITEMS) add_snippet();
         while (phase_items.size() > 0) offer(phase_items.pop_front());
      end

      // flush a held operator
      idle_pct  = 0;
      stall_pct = 0;
      offer(plain_row("+", 1'b0));
      offer(plain_row(8'h00, 1'b1));
      req_valid <= 1'b0;

      // drain
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
